// File: src/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared types for the trial division prime test: controller states and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_EVAL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;         // take a new item
      logic div_start;    // clear remainder, load dividend
      logic div_step;     // one restoring division step
      logic next_div;     // advance to the next divisor
      logic set_verdict;  // capture the verdict
      logic verdict;
      logic out_load;     // move the verdict into the output register
   } cmd_type;

   typedef struct packed {
      logic n_small;      // negative, zero or one
      logic sq_over;      // divisor squared exceeds the number
      logic div_last;     // final division step
      logic rem_zero;
      logic out_free;     // output register can take an item
   } status_type;

endpackage

`default_nettype wire

// File: src/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// reports whether a signed integer is prime by trial division
// ----------------------------------------------------------------------------
// One item is worked on at a time. Values below four are settled by the
// bound check without any division. Otherwise the divisor 2 and then the
// odd divisors from 3 upward are tried while their square does not exceed
// the value; each trial runs the restoring remainder unit, which takes
// one bit of the value per cycle. A composite stops at its smallest factor.
// The finished item sits in an output register, so the next item is taken
// while the result still waits for rsp_tready.
`default_nettype none

module trial_division_prime_test #(
   parameter int WIDTH = 32,
   localparam int DataW = ((WIDTH + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [DataW-1:0] req_tdata,   // value
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata    // is_prime
);
   import tdpt_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       is_prime;

   tdpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tdpt_dp #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_value    ($signed(req_tdata[WIDTH-1:0])),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_is_prime (is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   assign rsp_tdata = {7'b0, is_prime};

endmodule

`default_nettype wire

// File: src/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// controller for the trial division: bound check, bit serial remainder,
// divisor advance and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire tdpt_pkg::status_type  status,
   output tdpt_pkg::cmd_type          cmd
);
   import tdpt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.n_small || status.sq_over) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_last) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.rem_zero) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_CHECK: begin
            if (status.n_small) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = 1'b0;
            end else if (status.sq_over) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
         end
         S_EVAL: begin
            if (status.rem_zero) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict     = 1'b0;
            end else begin
               cmd.next_div = 1'b1;
            end
         end
         S_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/tdpt_dp.sv
// ----------------------------------------------------------------------------
// tdpt_dp
// datapath: number, divisor and its square, restoring remainder unit and
// the output register
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_dp #(
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic signed [WIDTH-1:0]  req_value,
   input  wire logic                     rsp_tready,
   output logic                          rsp_tvalid,
   output logic                          rsp_is_prime,
   input  wire tdpt_pkg::cmd_type        cmd,
   output tdpt_pkg::status_type          status
);
   import tdpt_pkg::*;

   localparam int DW = WIDTH / 2 + 1;
   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] sq_ff, sq_in;
   logic [DW-1:0]    d_ff, d_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [WIDTH-1:0] sh_ff, sh_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             verdict_ff, verdict_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_bit_ff, rsp_bit_in;
   logic [DW:0]      trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      sq_ff      <= sq_in;
      d_ff       <= d_in;
      rem_ff     <= rem_in;
      sh_ff      <= sh_in;
      cnt_ff     <= cnt_in;
      verdict_ff <= verdict_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   assign trial = {rem_ff, sh_ff[WIDTH-1]};

   always_comb begin
      n_in       = n_ff;
      sq_in      = sq_ff;
      d_in       = d_ff;
      rem_in     = rem_ff;
      sh_in      = sh_ff;
      cnt_in     = cnt_ff;
      verdict_in = verdict_ff;
      rsp_bit_in = rsp_bit_ff;
      if (cmd.load) begin
         n_in  = $unsigned(req_value);
         d_in  = DW'(2);
         sq_in = WIDTH'(4);
      end
      if (cmd.div_start) begin
         rem_in = '0;
         sh_in  = n_ff;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = DW'(trial - {1'b0, d_ff});
         end else begin
            rem_in = trial[DW-1:0];
         end
         sh_in  = {sh_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
      end
      // after two only odd divisors are tried
      if (cmd.next_div) begin
         if (d_ff == DW'(2)) begin
            d_in  = DW'(3);
            sq_in = WIDTH'(9);
         end else begin
            d_in  = d_ff + DW'(2);
            sq_in = sq_ff + (WIDTH'(d_ff) << 2) + WIDTH'(4);
         end
      end
      if (cmd.set_verdict) begin
         verdict_in = cmd.verdict;
      end
      if (cmd.out_load) begin
         rsp_bit_in = verdict_ff;
      end
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign status.n_small  = n_ff[WIDTH-1] || (n_ff[WIDTH-2:0] <= (WIDTH-1)'(1));
   assign status.sq_over  = sq_ff > n_ff;
   assign status.div_last = cnt_ff == CW'(WIDTH - 1);
   assign status.rem_zero = rem_ff == '0;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_is_prime = rsp_bit_ff;

endmodule

`default_nettype wire

// File: src/tdpt_checker.sv
// ----------------------------------------------------------------------------
// tdpt_checker
// port level checks for the trial division prime test
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one item at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while busy");

   // padding bits stay clear
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'b0)
      else $error("result padding not zero");

   // no result right out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
